[rtl/necir_pkg.sv]
// Shared types and constants for the NEC infrared edge decoder.
`default_nettype none
package necir_pkg;

	localparam int QUEUE_DEPTH_DEF = 8;

	localparam int CFG_W  = 20;
	localparam int TIME_W = 32;
	localparam int WORD_W = 16;

	// item opcodes
	localparam logic [1:0] OP_EDGE    = 2'd0;
	localparam logic [1:0] OP_TIMEOUT = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_BIT_ONE_MIN      = 3'd0;
	localparam logic [2:0] REG_BIT_ONE_MAX      = 3'd1;
	localparam logic [2:0] REG_REPEAT_GAP_MIN   = 3'd2;
	localparam logic [2:0] REG_REPEAT_GAP_MAX   = 3'd3;
	localparam logic [2:0] REG_REPEAT_SHORT     = 3'd4;
	localparam logic [2:0] REG_REPEAT_FRAME_MIN = 3'd5;
	localparam logic [2:0] REG_REPEAT_FRAME_MAX = 3'd6;
	localparam logic [2:0] REG_TIMEOUT          = 3'd7;

	localparam logic [CFG_W-1:0] RST_BIT_ONE_MIN      = 20'd1200;
	localparam logic [CFG_W-1:0] RST_BIT_ONE_MAX      = 20'd2000;
	localparam logic [CFG_W-1:0] RST_REPEAT_GAP_MIN   = 20'd35000;
	localparam logic [CFG_W-1:0] RST_REPEAT_GAP_MAX   = 20'd45000;
	localparam logic [CFG_W-1:0] RST_REPEAT_SHORT     = 20'd8000;
	localparam logic [CFG_W-1:0] RST_REPEAT_FRAME_MIN = 20'd94000;
	localparam logic [CFG_W-1:0] RST_REPEAT_FRAME_MAX = 20'd100000;
	localparam logic [CFG_W-1:0] RST_TIMEOUT          = 20'd100000;

	localparam logic [4:0] BITS_PER_WORD = 5'd16;

	typedef struct packed {
		logic [CFG_W-1:0] bit_one_min;
		logic [CFG_W-1:0] bit_one_max;
		logic [CFG_W-1:0] repeat_gap_min;
		logic [CFG_W-1:0] repeat_gap_max;
		logic [CFG_W-1:0] repeat_short;
		logic [CFG_W-1:0] repeat_frame_min;
		logic [CFG_W-1:0] repeat_frame_max;
		logic [CFG_W-1:0] timeout;
	} cfg_t;

	// frame is {data_word, addr_word}
	typedef struct packed {
		logic                  valid;
		logic [2*WORD_W-1:0]   frame;
	} push_t;

	typedef struct packed {
		logic queued;
		logic dropped;
	} evt_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qflags_t;

endpackage
`default_nettype wire

[rtl/necir_cmd_if.sv]
// Input item channel: opcode, pin level and time stamp.
`default_nettype none
interface necir_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic        level;
	logic [31:0] now_us;

	modport source (output valid, output opcode, output level, output now_us, input ready);
	modport sink   (input valid, input opcode, input level, input now_us, output ready);
endinterface
`default_nettype wire

[rtl/necir_rsp_if.sv]
// Result channel: popped frame, queue level, events and decoder state.
`default_nettype none
interface necir_rsp_if;
	logic        valid;
	logic        ready;
	logic        read_valid;
	logic [15:0] addr_word;
	logic [15:0] data_word;
	logic [2:0]  pending;
	logic        frame_queued;
	logic        frame_dropped;
	logic [2:0]  rx_state;

	modport source (output valid, output read_valid, output addr_word, output data_word,
		output pending, output frame_queued, output frame_dropped, output rx_state,
		input ready);
	modport sink   (input valid, input read_valid, input addr_word, input data_word,
		input pending, input frame_queued, input frame_dropped, input rx_state,
		output ready);
endinterface
`default_nettype wire

[rtl/necir_decode.sv]
// NEC frame decode state machine: edge timing, bit shifting and frame checks.
`default_nettype none
module necir_decode (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire logic [1:0]          opcode,
	input  wire logic                level,
	input  wire logic [31:0]         now_us,
	input  wire necir_pkg::cfg_t     cfg,
	input  wire necir_pkg::qflags_t  qflags,
	output necir_pkg::push_t         push,
	output necir_pkg::evt_t          evt,
	output logic [2:0]               rx_state
);
	import necir_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_SYNC    = 3'd1,
		ST_ADDR    = 3'd2,
		ST_DATA    = 3'd3,
		ST_REPEAT0 = 3'd4,
		ST_REPEAT1 = 3'd5
	} state_t;

	state_t              state_q, state_n;
	logic [TIME_W-1:0]   last_q;
	logic [WORD_W-1:0]   addr_q, addr_n;
	logic [WORD_W-1:0]   data_q, data_n;
	logic [4:0]          abits_q, abits_n;
	logic [4:0]          dbits_q, dbits_n;
	logic [TIME_W-1:0]   gap;
	logic                is_one;
	logic                rpt_win;
	logic                restart;
	logic                enq;
	logic                frame_ok;
	logic                want;

	assign gap     = now_us - last_q;
	assign is_one  = (gap > TIME_W'(cfg.bit_one_min)) && (gap < TIME_W'(cfg.bit_one_max));
	assign rpt_win = (gap > TIME_W'(cfg.repeat_gap_min)) && (gap < TIME_W'(cfg.repeat_gap_max));

	always_comb begin
		state_n = state_q;
		addr_n  = addr_q;
		data_n  = data_q;
		abits_n = abits_q;
		dbits_n = dbits_q;
		restart = 1'b0;
		enq     = 1'b0;
		if (opcode == OP_EDGE) begin
			unique case (state_q)
				ST_IDLE: begin
					if (!level) restart = 1'b1;
				end
				ST_SYNC: begin
					if (!level) state_n = ST_ADDR;
				end
				ST_ADDR: begin
					if (!level) begin
						addr_n  = {is_one, addr_q[WORD_W-1:1]};
						abits_n = abits_q + 5'd1;
						if (abits_n >= BITS_PER_WORD) state_n = ST_DATA;
					end
				end
				ST_DATA: begin
					if (!level) begin
						data_n  = {is_one, data_q[WORD_W-1:1]};
						dbits_n = dbits_q + 5'd1;
						if (dbits_n >= BITS_PER_WORD) begin
							enq     = 1'b1;
							state_n = ST_IDLE;
						end
					end
				end
				ST_REPEAT0: begin
					if (level) begin
						if (gap < TIME_W'(cfg.repeat_short)) state_n = ST_IDLE;
						else enq = 1'b1;
					end else begin
						state_n = ST_REPEAT1;
					end
				end
				ST_REPEAT1: begin
					if (!level) begin
						priority if (gap < TIME_W'(cfg.repeat_frame_min)) state_n = ST_IDLE;
						else if (gap > TIME_W'(cfg.repeat_frame_max)) restart = 1'b1;
						else state_n = ST_REPEAT0;
					end
				end
				default: ;
			endcase
			// falling edge that starts over (in idle, or after an overlong repeat frame): repeat lead-in or a fresh frame
			if (restart) begin
				if (rpt_win) begin
					state_n = ST_REPEAT0;
				end else begin
					addr_n  = '0;
					data_n  = '0;
					abits_n = '0;
					dbits_n = '0;
					state_n = ST_SYNC;
				end
			end
		end else if (opcode == OP_TIMEOUT) begin
			if (state_q != ST_IDLE && state_q != ST_REPEAT1 && gap > TIME_W'(cfg.timeout))
				state_n = ST_IDLE;
		end
	end

	assign frame_ok = (addr_n[15:8] == ~addr_n[7:0]) && (data_n[15:8] == ~data_n[7:0]);
	assign want     = enq && frame_ok;

	assign push.valid  = want && !qflags.full;
	assign push.frame  = {data_n, addr_n};
	assign evt.queued  = want && !qflags.full;
	assign evt.dropped = want && qflags.full;
	assign rx_state    = state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= '0;
			addr_q  <= '0;
			data_q  <= '0;
			abits_q <= '0;
			dbits_q <= '0;
		end else if (step) begin
			state_q <= state_n;
			addr_q  <= addr_n;
			data_q  <= data_n;
			abits_q <= abits_n;
			dbits_q <= dbits_n;
			if (opcode == OP_EDGE) last_q <= now_us;
		end
	end

endmodule
`default_nettype wire

[rtl/necir_queue.sv]
// Ring queue of decoded frames with a registered head read.
`default_nettype none
module necir_queue #(
	parameter int QUEUE_DEPTH = necir_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire necir_pkg::push_t              push,
	input  wire logic                          pop,
	output necir_pkg::qflags_t                 qflags,
	output logic [2*necir_pkg::WORD_W-1:0]     head,
	output logic [$clog2(QUEUE_DEPTH)-1:0]     count_n
);
	import necir_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [2*WORD_W-1:0] mem [QUEUE_DEPTH];
	logic [2*WORD_W-1:0] head_q;
	logic [PW-1:0]       wp_q, rp_q, wp_n, rp_n, wp_inc, rp_inc;
	logic [PW:0]         diff;

	assign wp_inc = (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + PW'(1);
	assign rp_inc = (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + PW'(1);
	assign wp_n   = push.valid ? wp_inc : wp_q;
	assign rp_n   = pop ? rp_inc : rp_q;

	assign qflags.empty = (wp_q == rp_q);
	assign qflags.full  = (wp_inc == rp_q);

	// occupancy after this item, modulo the depth
	assign diff    = (PW+1)'(wp_n) + (PW+1)'(QUEUE_DEPTH) - (PW+1)'(rp_n);
	assign count_n = (diff >= (PW+1)'(QUEUE_DEPTH)) ? PW'(diff - (PW+1)'(QUEUE_DEPTH))
		: PW'(diff);

	assign head = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			wp_q <= wp_n;
			rp_q <= rp_n;
		end
	end

	// head tracks the entry at the next read pointer; bypass a push written into the slot at that pointer
	always_ff @(posedge clk) begin
		if (push.valid) mem[wp_q] <= push.frame;
		if (push.valid && wp_q == rp_n) head_q <= push.frame;
		else head_q <= mem[rp_n];
	end

endmodule
`default_nettype wire

[rtl/nec_ir_edge_decoder.sv]
// NEC infrared edge decoder, top level.
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle while results are taken; the decode update and queue access fit in one stage.
// Queue head is read from a registered memory port that is refreshed every cycle.
// Reset (arst_n low) clears decoder state, queue pointers and handshake state and loads
// the default thresholds; queue contents are not cleared.
`default_nettype none
module nec_ir_edge_decoder #(
	parameter int QUEUE_DEPTH = necir_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [2:0]                 cfg_index,
	input  wire logic [necir_pkg::CFG_W-1:0] cfg_data,
	necir_cmd_if.sink                       cmd,
	necir_rsp_if.source                     rsp
);
	import necir_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	cfg_t                cfg_q;
	logic                valid_s1;
	logic [1:0]          opcode_s1;
	logic                level_s1;
	logic [TIME_W-1:0]   now_s1;
	logic                adv;
	logic                step;
	logic                pop;
	push_t               push;
	push_t               q_push;
	evt_t                evt;
	qflags_t             qflags;
	logic [2*WORD_W-1:0] head;
	logic [PW-1:0]       count_n;
	logic [2:0]          rx_state;
	logic                out_valid_q;
	logic                read_valid_q;
	logic [WORD_W-1:0]   addr_word_q;
	logic [WORD_W-1:0]   data_word_q;
	logic [2:0]          pending_q;
	logic                queued_q;
	logic                dropped_q;
	logic [2:0]          rx_state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_one_min      <= RST_BIT_ONE_MIN;
			cfg_q.bit_one_max      <= RST_BIT_ONE_MAX;
			cfg_q.repeat_gap_min   <= RST_REPEAT_GAP_MIN;
			cfg_q.repeat_gap_max   <= RST_REPEAT_GAP_MAX;
			cfg_q.repeat_short     <= RST_REPEAT_SHORT;
			cfg_q.repeat_frame_min <= RST_REPEAT_FRAME_MIN;
			cfg_q.repeat_frame_max <= RST_REPEAT_FRAME_MAX;
			cfg_q.timeout          <= RST_TIMEOUT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BIT_ONE_MIN:      cfg_q.bit_one_min      <= cfg_data;
				REG_BIT_ONE_MAX:      cfg_q.bit_one_max      <= cfg_data;
				REG_REPEAT_GAP_MIN:   cfg_q.repeat_gap_min   <= cfg_data;
				REG_REPEAT_GAP_MAX:   cfg_q.repeat_gap_max   <= cfg_data;
				REG_REPEAT_SHORT:     cfg_q.repeat_short     <= cfg_data;
				REG_REPEAT_FRAME_MIN: cfg_q.repeat_frame_min <= cfg_data;
				REG_REPEAT_FRAME_MAX: cfg_q.repeat_frame_max <= cfg_data;
				REG_TIMEOUT:          cfg_q.timeout          <= cfg_data;
			endcase
		end
	end

	// result register frees when empty or taken this cycle
	assign adv       = !out_valid_q || rsp.ready;
	assign step      = valid_s1 && adv;
	assign cmd.ready = !valid_s1 || adv;
	assign pop       = step && opcode_s1 == OP_READ && !qflags.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (cmd.ready) valid_s1 <= cmd.valid;
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			opcode_s1 <= cmd.opcode;
			level_s1  <= cmd.level;
			now_s1    <= cmd.now_us;
		end
	end

	necir_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.opcode   (opcode_s1),
		.level    (level_s1),
		.now_us   (now_s1),
		.cfg      (cfg_q),
		.qflags   (qflags),
		.push     (push),
		.evt      (evt),
		.rx_state (rx_state)
	);

	assign q_push.valid = push.valid && step;
	assign q_push.frame = push.frame;

	necir_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.pop     (pop),
		.qflags  (qflags),
		.head    (head),
		.count_n (count_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (step) out_valid_q <= 1'b1;
		else if (rsp.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step) begin
			read_valid_q <= pop;
			addr_word_q  <= pop ? head[WORD_W-1:0] : '0;
			data_word_q  <= pop ? head[2*WORD_W-1:WORD_W] : '0;
			pending_q    <= 3'(count_n);
			queued_q     <= evt.queued;
			dropped_q    <= evt.dropped;
			rx_state_q   <= rx_state;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.read_valid    = read_valid_q;
	assign rsp.addr_word     = addr_word_q;
	assign rsp.data_word     = data_word_q;
	assign rsp.pending       = pending_q;
	assign rsp.frame_queued  = queued_q;
	assign rsp.frame_dropped = dropped_q;
	assign rsp.rx_state      = rx_state_q;

endmodule
`default_nettype wire

[rtl/necir_checker.sv]
// Port-level assertions for the NEC infrared edge decoder, bound to the top level.
`default_nettype none
module necir_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic        read_valid,
	input wire logic [15:0] addr_word,
	input wire logic [15:0] data_word,
	input wire logic        frame_queued,
	input wire logic        frame_dropped,
	input wire logic [2:0]  rx_state
);

	localparam logic [2:0] RX_IDLE    = 3'd0;
	localparam logic [2:0] RX_REPEAT0 = 3'd4;

	// a stalled result transaction keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(addr_word) && $stable(data_word)
			&& $stable(read_valid) && $stable(rx_state))
		else $error("result changed while stalled");

	a_push_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(frame_queued && frame_dropped) && !(read_valid && frame_queued))
		else $error("conflicting queue events in one result");

	a_no_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !read_valid |-> addr_word == 16'd0 && data_word == 16'd0)
		else $error("frame words set without a read");

	// a frame completes only from the data state (back to idle) or a repeat burst
	a_push_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (frame_queued || frame_dropped) |-> rx_state == RX_IDLE
			|| rx_state == RX_REPEAT0)
		else $error("frame event in unexpected decoder state");

endmodule

bind nec_ir_edge_decoder necir_checker u_necir_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.read_valid    (rsp.read_valid),
	.addr_word     (rsp.addr_word),
	.data_word     (rsp.data_word),
	.frame_queued  (rsp.frame_queued),
	.frame_dropped (rsp.frame_dropped),
	.rx_state      (rsp.rx_state)
);
`default_nettype wire
